// File: rtl/sorted_unique_set_table_top_defines.svh
// Assertion macros shared by the sorted set table RTL.
`ifndef SORTED_UNIQUE_SET_TABLE_TOP_DEFINES_SVH
`define SORTED_UNIQUE_SET_TABLE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define SUST_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sust assertion failed");
// Checked on every clock edge, reset included.
`define SUST_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sust assertion failed");
`else
`define SUST_ASSERT(lbl, clk, rst_n, prop)
`define SUST_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// File: rtl/sust_pkg.sv
// Shared types and constants of the sorted set table.
package sust_pkg;

  localparam int CAPACITY = 64;
  localparam int VAL_W    = 32;
  localparam int POS_W    = 7;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef logic [1:0]              mode_t;
  typedef logic [1:0]              status_t;
  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam mode_t MODE_SEARCH = 2'd0;
  localparam mode_t MODE_INSERT = 2'd1;
  localparam mode_t MODE_REMOVE = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_PRESENT = 2'd1;
  localparam status_t ST_ABSENT  = 2'd2;
  localparam status_t ST_FULL    = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef struct packed {
    logic capture;
    logic compare;
    logic update;
  } ctl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

// File: rtl/sust_ifs.sv
// Valid/ready channel interfaces for requests and responses.
interface sust_req_if;
  logic             valid;
  logic             ready;
  sust_pkg::mode_t  mode;
  sust_pkg::value_t value;
  modport source (output valid, output mode, output value, input ready);
  modport sink (input valid, input mode, input value, output ready);
endinterface

interface sust_rsp_if;
  logic              valid;
  logic              ready;
  sust_pkg::status_t status;
  sust_pkg::pos_t    position;
  sust_pkg::pos_t    occupancy;
  modport source (output valid, output status, output position, output occupancy, input ready);
  modport sink (input valid, input status, input position, input occupancy, output ready);
endinterface

// File: rtl/sorted_unique_set_table_top.sv
// Sorted set table: search, insert and remove over an ordered cell chain.
// A request is captured, compared in S_CMP, then S_UPD loads the response register.
// Each request takes a parallel compare step, then a shift/update step.
// A stalled response holds the update cycle; a new request enters as the previous one retires.
// Reset (synchronous, active low) empties the table; cell contents are not cleared.
module sorted_unique_set_table_top (
  input  logic       clk,
  input  logic       rst_n,
  sust_req_if.sink   in_ch,
  sust_rsp_if.source out_ch
);
  import sust_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  sust_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  sust_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_mode       (in_ch.mode),
    .in_value      (in_ch.value),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_position  (out_ch.position),
    .out_occupancy (out_ch.occupancy)
  );

endmodule

// File: rtl/sust_ctrl.sv
// Request sequencer: accept, compare, update.
module sust_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  sust_pkg::dp_stat_t stat,
  output sust_pkg::ctl_cmd_t cmd
);
  import sust_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CMP;
      end
      S_CMP: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (!stat.out_busy) state_nxt = in_valid ? S_CMP : S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.compare = 1'b0;
    cmd.update  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
      end
      S_UPD: begin
        // next beat may enter as this one retires
        in_ready   = !stat.out_busy;
        cmd.update = !stat.out_busy;
      end
      default: ;
    endcase
    cmd.capture = in_valid && in_ready;
  end

endmodule

// File: rtl/sust_dp.sv
// Sorted cell chain, compare vectors, rank encoder and response register.
`include "sorted_unique_set_table_top_defines.svh"
module sust_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sust_pkg::ctl_cmd_t cmd,
  output sust_pkg::dp_stat_t stat,
  input  sust_pkg::mode_t    in_mode,
  input  sust_pkg::value_t   in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output sust_pkg::status_t  out_status,
  output sust_pkg::pos_t     out_position,
  output sust_pkg::pos_t     out_occupancy
);
  import sust_pkg::*;

  value_t              cells_r [CAPACITY];
  mode_t               mode_r;
  value_t              key_r;
  cnt_t                count_r, count_nxt;
  logic [CAPACITY-1:0] lt_r, eq_r;
  logic                out_valid_r;
  status_t             status_r, status_nxt;
  pos_t                pos_r, pos_nxt;
  pos_t                occ_r;

  logic [CAPACITY+1:0] lt_ext;
  logic [CAPACITY:0]   bnd;
  cnt_t                idx;
  logic                hit, full, ins_do, rem_do;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      key_r  <= in_value;
    end
  end

  // every occupied cell compares against the key at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= '0;
      eq_r <= '0;
    end else if (cmd.compare) begin
      for (int i = 0; i < CAPACITY; i++) begin
        lt_r[i] <= (cnt_t'(i) < count_r) && (cells_r[i] < key_r);
        eq_r[i] <= (cnt_t'(i) < count_r) && (cells_r[i] == key_r);
      end
    end
  end

  // lt is a thermometer; its edge marks the insert/hit slot
  always_comb begin
    lt_ext = {1'b0, lt_r, 1'b1};
    bnd    = lt_ext[CAPACITY:0] & ~lt_ext[CAPACITY+1:1];
    idx    = '0;
    for (int i = 0; i <= CAPACITY; i++) begin
      if (bnd[i]) idx = idx | cnt_t'(i);
    end
  end

  always_comb begin
    hit        = |eq_r;
    full       = (count_r == cnt_t'(CAPACITY));
    ins_do     = 1'b0;
    rem_do     = 1'b0;
    count_nxt  = count_r;
    status_nxt = hit ? ST_OK : ST_ABSENT;
    pos_nxt    = hit ? pos_t'(idx + cnt_t'(1)) : '0;
    case (mode_r)
      MODE_INSERT: begin
        if (hit) begin
          status_nxt = ST_PRESENT;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          ins_do     = 1'b1;
          count_nxt  = count_r + cnt_t'(1);
          status_nxt = ST_OK;
          pos_nxt    = pos_t'(idx + cnt_t'(1));
        end
      end
      MODE_REMOVE: begin
        if (hit) begin
          rem_do    = 1'b1;
          count_nxt = count_r - cnt_t'(1);
        end
      end
      default: ;
    endcase
  end

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      always_ff @(posedge clk) begin
        if (cmd.update && !lt_r[g]) begin
          if (ins_do) begin
            if (g == 0) begin
              cells_r[g] <= key_r;
            end else begin
              cells_r[g] <= bnd[g] ? key_r : cells_r[(g == 0) ? 0 : g-1];
            end
          end else if (rem_do && (g < CAPACITY-1)) begin
            cells_r[g] <= cells_r[(g < CAPACITY-1) ? g+1 : g];
          end
        end
      end
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.update) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      status_r <= status_nxt;
      pos_r    <= pos_nxt;
      occ_r    <= pos_t'(count_nxt);
    end
  end

  assign stat.out_busy = out_valid_r && !out_ready;
  assign out_valid     = out_valid_r;
  assign out_status    = status_r;
  assign out_position  = pos_r;
  assign out_occupancy = occ_r;

  `SUST_ASSERT(a_count_cap, clk, rst_n, count_r <= cnt_t'(CAPACITY))
  `SUST_ASSERT(a_lt_thermo, clk, rst_n, ((lt_r >> 1) & ~lt_r) == '0)
  `SUST_ASSERT(a_eq_onehot, clk, rst_n, $onehot0(eq_r))
  `SUST_ASSERT(a_hit_at_edge, clk, rst_n, ((eq_r & ~bnd[CAPACITY-1:0]) == '0))
  `SUST_ASSERT_ALWAYS(a_update_free, clk, !(cmd.update && out_valid_r && !out_ready))

endmodule
